// ----- hw/rtl/cs0u8_pkg.sv -----
package cs0u8_pkg;

    localparam int BYTE_W   = 8;
    localparam int MAX_BEATS = 3;
    localparam int BEAT_W   = 2;

    // compression ids
    localparam logic [BYTE_W-1:0] ID_LATIN1 = 8'd8;
    localparam logic [BYTE_W-1:0] ID_UNIT16 = 8'd16;

    localparam logic [BYTE_W-1:0] LEAD2     = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3     = 8'hE0;
    localparam logic [BYTE_W-1:0] CONT      = 8'h80;
    localparam logic [15:0]       ONE_LIMIT = 16'h0080;
    localparam logic [15:0]       TWO_LIMIT = 16'h0800;

    typedef enum logic [1:0] {
        MODE_RAW   = 2'd0,
        MODE_LATIN = 2'd1,
        MODE_UNIT  = 2'd2
    } mode_t;

    // one input item's worth of results, waiting to be sent out one beat a cycle while res_ready does not stall
    typedef struct packed {
        logic [MAX_BEATS-1:0][BYTE_W-1:0] bytes;
        logic [BEAT_W-1:0]                last_idx;
        logic                             byte_ok;
        logic                             str_end;
    } group_t;

endpackage

// ----- hw/rtl/cs0u8_decode.sv -----
module cs0u8_decode
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        take,
    input  logic [cs0u8_pkg::BYTE_W-1:0] data_byte,
    input  logic                        is_first,
    input  logic                        is_last,
    output logic                        has_result,
    output cs0u8_pkg::group_t           grp
);

    cs0u8_pkg::mode_t               mode_reg, mode_next;
    logic                           high_held_reg, high_held_next;
    logic [cs0u8_pkg::BYTE_W-1:0]   high_byte_reg, high_byte_next;

    logic [15:0]                    unit;
    logic [cs0u8_pkg::BEAT_W-1:0]   n;

    assign unit = {high_byte_reg, data_byte};

    always_comb
    begin
        n = '0;
        grp.bytes = '0;
        if (is_first)
        begin
            if (data_byte != cs0u8_pkg::ID_LATIN1 && data_byte != cs0u8_pkg::ID_UNIT16)
            begin
                grp.bytes[0] = data_byte;
                n = 2'd1;
            end
        end
        else
        begin
            case (mode_reg)
                cs0u8_pkg::MODE_LATIN:
                begin
                    if (!data_byte[7])
                    begin
                        grp.bytes[0] = data_byte;
                        n = 2'd1;
                    end
                    else
                    begin
                        grp.bytes[0] = cs0u8_pkg::LEAD2 | {6'd0, data_byte[7:6]};
                        grp.bytes[1] = cs0u8_pkg::CONT | {2'd0, data_byte[5:0]};
                        n = 2'd2;
                    end
                end
                cs0u8_pkg::MODE_UNIT:
                begin
                    if (high_held_reg)
                    begin
                        if (unit < cs0u8_pkg::ONE_LIMIT)
                        begin
                            grp.bytes[0] = unit[7:0];
                            n = 2'd1;
                        end
                        else if (unit < cs0u8_pkg::TWO_LIMIT)
                        begin
                            grp.bytes[0] = cs0u8_pkg::LEAD2 | {3'd0, unit[10:6]};
                            grp.bytes[1] = cs0u8_pkg::CONT | {2'd0, unit[5:0]};
                            n = 2'd2;
                        end
                        else
                        begin
                            grp.bytes[0] = cs0u8_pkg::LEAD3 | {4'd0, unit[15:12]};
                            grp.bytes[1] = cs0u8_pkg::CONT | {2'd0, unit[11:6]};
                            grp.bytes[2] = cs0u8_pkg::CONT | {2'd0, unit[5:0]};
                            n = 2'd3;
                        end
                    end
                end
                default:
                begin
                    grp.bytes[0] = data_byte;
                    n = 2'd1;
                end
            endcase
        end

        // a last item with nothing to say still closes the string with a marker
        has_result   = (n != '0) || is_last;
        grp.byte_ok  = (n != '0);
        grp.str_end  = is_last;
        grp.last_idx = (n == '0) ? '0 : n - 2'd1;
    end

    always_comb
    begin
        mode_next      = mode_reg;
        high_held_next = high_held_reg;
        high_byte_next = high_byte_reg;
        if (is_first)
        begin
            high_held_next = 1'b0;
            high_byte_next = '0;
            if (data_byte == cs0u8_pkg::ID_LATIN1)
                mode_next = cs0u8_pkg::MODE_LATIN;
            else if (data_byte == cs0u8_pkg::ID_UNIT16)
                mode_next = cs0u8_pkg::MODE_UNIT;
            else
                mode_next = cs0u8_pkg::MODE_RAW;
        end
        else if (mode_reg == cs0u8_pkg::MODE_UNIT)
        begin
            if (!high_held_reg)
            begin
                high_byte_next = data_byte;
                high_held_next = 1'b1;
            end
            else
            begin
                high_byte_next = '0;
                high_held_next = 1'b0;
            end
        end
        if (is_last)
        begin
            high_held_next = 1'b0;
            high_byte_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= cs0u8_pkg::MODE_RAW;
            high_held_reg <= 1'b0;
            high_byte_reg <= '0;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            high_held_reg <= high_held_next;
            high_byte_reg <= high_byte_next;
        end
    end

endmodule

// ----- hw/rtl/cs0u8_serial.sv -----
module cs0u8_serial
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  cs0u8_pkg::group_t            grp_in,
    output logic                         can_load,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [cs0u8_pkg::BYTE_W-1:0] out_byte,
    output logic                         out_valid,
    output logic                         run_last,
    output logic                         string_end
);

    cs0u8_pkg::group_t              grp_reg;
    logic                           grp_vld_reg;
    logic [cs0u8_pkg::BEAT_W-1:0]   idx_reg;

    logic                           res_valid_reg;
    logic [cs0u8_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                           out_valid_reg;
    logic                           run_last_reg;
    logic                           string_end_reg;

    logic                           move;
    logic                           grp_last;

    assign move     = grp_vld_reg && (!res_valid_reg || res_ready);
    assign grp_last = (idx_reg == grp_reg.last_idx);
    assign can_load = !grp_vld_reg || (move && grp_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_vld_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else if (load)
        begin
            grp_vld_reg <= 1'b1;
            idx_reg     <= '0;
        end
        else if (move)
        begin
            if (grp_last)
                grp_vld_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= grp_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (move)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_byte_reg   <= grp_reg.bytes[idx_reg];
            out_valid_reg  <= grp_reg.byte_ok;
            run_last_reg   <= grp_last;
            string_end_reg <= grp_last && grp_reg.str_end;
        end
    end

    assign res_valid  = res_valid_reg;
    assign out_byte   = out_byte_reg;
    assign out_valid  = out_valid_reg;
    assign run_last   = run_last_reg;
    assign string_end = string_end_reg;

endmodule

// ----- hw/rtl/cs0_dstring_to_utf8_core.sv -----
// CS0 dstring to UTF-8 converter, one dstring byte per input item. Flag the
// compression id with is_first and the last used byte with is_last. Each item
// gives zero to three result beats, sent one a cycle through the single result
// port, which sets the rate while res_ready does not stall it. A new item is
// taken only when no beats are pending or as the last pending beat moves out;
// a 16-bit unit's high byte gives no beat and its low byte up to three. The
// first beat of an item passes the group register and then the output register;
// run_last marks the final beat of an item and string_end the beat closing the
// string (a marker beat with out_valid low if the last byte gave none).
module cs0_dstring_to_utf8_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [cs0u8_pkg::BYTE_W-1:0] data_byte,
    input  logic                         is_first,
    input  logic                         is_last,
    output logic                         res_valid,
    input  logic                         res_ready,
    output logic [cs0u8_pkg::BYTE_W-1:0] out_byte,
    output logic                         out_valid,
    output logic                         run_last,
    output logic                         string_end
);

    logic               take;
    logic               has_result;
    logic               can_load;
    cs0u8_pkg::group_t  grp;

    assign in_ready = can_load;
    assign take     = in_valid && can_load;

    cs0u8_decode u_decode
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .data_byte  (data_byte),
        .is_first   (is_first),
        .is_last    (is_last),
        .has_result (has_result),
        .grp        (grp)
    );

    cs0u8_serial u_serial
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (take && has_result),
        .grp_in     (grp),
        .can_load   (can_load),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .out_byte   (out_byte),
        .out_valid  (out_valid),
        .run_last   (run_last),
        .string_end (string_end)
    );

endmodule
